/* sv/crbe_pkg.sv */
`timescale 1ns / 1ps
// Shared types, byte codes and checksum helper of the cassette record bit encoder.
// No dependencies; the record and serializer modules and the top level import it.
package crbe_pkg;

	localparam logic [7:0] SYNC_BYTE  = 8'h55;
	localparam logic [7:0] CTRL_EOF   = 8'hFE;
	localparam logic [7:0] CTRL_FULL  = 8'hFC;
	localparam logic [7:0] CTRL_PART  = 8'hFA;

	// end-around-carry sum of 0x55, 0x55 and each control byte
	localparam logic [7:0] HDR_SUM_EOF  = 8'hA9;
	localparam logic [7:0] HDR_SUM_FULL = 8'hA7;
	localparam logic [7:0] HDR_SUM_PART = 8'hA5;

	localparam logic [6:0] LAST_SLOT  = 7'd127;
	localparam logic [7:0] FULL_COUNT = 8'd128;

	localparam logic SYM_SPACE = 1'b0;
	localparam logic SYM_MARK  = 1'b1;

	// symbol positions inside one serialized byte
	localparam logic [3:0] POS_START = 4'd0;
	localparam logic [3:0] POS_STOP  = 4'd9;

	// up to four bytes caused by one slot, byte 0 goes out first
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_byte;
	} byte_pkt_t;

	// handoff between record stage and serializer
	typedef struct packed {
		logic      valid;
		byte_pkt_t pkt;
	} pkt_chan_t;

	function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[7:0] + {7'd0, s[8]};
	endfunction

endpackage

/* sv/cassette_record_bit_encoder.sv */
`timescale 1ns / 1ps
// Top level of the cassette record bit encoder: slot stream in, serial tone symbols out.
// Depends on crbe_pkg, crbe_record and crbe_serializer.
//
//   channel  | direction | signals                              | content
//   ---------+-----------+--------------------------------------+--------------------------
//   s_axis   | in        | tvalid tready tdata[15:0] tuser[0:0] | one record slot
//   m_axis   | out       | tvalid tready tdata[7:0] tlast       | one serial tone symbol
//
// Each transfer in yields 10 symbols, 20 for slot 127 (byte plus checksum) and 40 for
// the slot that starts a record (two sync bytes, control byte, slot byte).
// The serializer puts out one symbol per cycle while m_axis is ready and a packet is waiting;
// on an idle path a slot's first symbol passes the handoff, packet and output registers in turn.
// A one-entry handoff register lets the next slot transfer in while the current one is
// still shifting out. Stalls on m_axis hold the output register and back up to s_axis.
// Reset (arst_n low) clears slot counter, checksum, length and all valid flags.
module cassette_record_bit_encoder import crbe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] slot_byte, [15:8] payload_count
	input  logic [0:0]  s_axis_tuser,  // [0] first_slot
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [0] tone_symbol, [7:1] zero
	output logic        m_axis_tlast   // last_of_run
);

	pkt_chan_t pkt_chan;
	logic      pkt_take;
	logic      tone_symbol;

	// select bytes and keep the record state per accepted slot
	crbe_record u_record (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.slot_byte     (s_axis_tdata[7:0]),
		.first_slot    (s_axis_tuser[0]),
		.payload_count (s_axis_tdata[15:8]),
		.pkt_out       (pkt_chan),
		.pkt_take      (pkt_take)
	);

	// shift the bytes out as framed serial symbols
	crbe_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.pkt_in     (pkt_chan),
		.pkt_take   (pkt_take),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_symbol (tone_symbol),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {7'd0, tone_symbol};

	// an accepted slot always lands in the handoff register
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> pkt_chan.valid)
		else $error("accepted slot did not reach the handoff register");

	// after the serializer takes a packet, m_axis shows a valid symbol
	a_take_emits: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_take |-> ##2 m_axis_tvalid)
		else $error("serializer took a packet but produced no symbol");

	// the final symbol of a slot is always a stop bit
	a_last_is_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[0] == SYM_MARK)
		else $error("last symbol of a slot is not a mark stop bit");

	// the handoff register is never overwritten while it still holds a packet
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_chan.valid && !pkt_take |-> !s_axis_tready)
		else $error("input ready while handoff register is full");

endmodule

/* sv/crbe_record.sv */
`timescale 1ns / 1ps
// Record stage: slot counter, latched length, running checksum and byte selection.
// Depends on crbe_pkg; feeds crbe_serializer through a one-entry handoff register.
module crbe_record import crbe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] slot_byte,
	input  logic       first_slot,
	input  logic [7:0] payload_count,
	output pkt_chan_t  pkt_out,
	input  logic       pkt_take
);

	logic [6:0] slot_index_q;
	logic [7:0] record_length_q;
	logic [7:0] running_sum_q;
	logic       pkt_valid_s1;
	byte_pkt_t  pkt_s1;

	logic       start;
	logic [7:0] len;
	logic [6:0] idx;
	logic [7:0] val;
	logic [7:0] ctrl;
	logic [7:0] hdr_sum;
	logic [7:0] base_sum;
	logic [7:0] new_sum;
	logic       accept;
	byte_pkt_t  pkt_d;

	assign in_ready = !pkt_valid_s1 || pkt_take;
	assign accept   = in_valid && in_ready;

	always_comb begin
		start = first_slot || (slot_index_q == '0);
		if (start) begin
			len = (payload_count > FULL_COUNT) ? FULL_COUNT : payload_count;
			idx = '0;
		end else begin
			len = record_length_q;
			idx = slot_index_q;
		end

		if (len == '0) begin
			ctrl    = CTRL_EOF;
			hdr_sum = HDR_SUM_EOF;
		end else if (len == FULL_COUNT) begin
			ctrl    = CTRL_FULL;
			hdr_sum = HDR_SUM_FULL;
		end else begin
			ctrl    = CTRL_PART;
			hdr_sum = HDR_SUM_PART;
		end

		// padding and end-of-file slots carry zero, a partial record ends on its length
		if (len == '0)
			val = '0;
		else if (len == FULL_COUNT)
			val = slot_byte;
		else if (idx == LAST_SLOT)
			val = len;
		else if ({1'b0, idx} < len)
			val = slot_byte;
		else
			val = '0;

		base_sum = start ? hdr_sum : running_sum_q;
		new_sum  = eac_add(base_sum, val);

		pkt_d = '0;
		if (start) begin
			pkt_d.bytes     = {val, ctrl, SYNC_BYTE, SYNC_BYTE};
			pkt_d.last_byte = 2'd3;
		end else if (idx == LAST_SLOT) begin
			pkt_d.bytes     = {8'd0, 8'd0, new_sum, val};
			pkt_d.last_byte = 2'd1;
		end else begin
			pkt_d.bytes     = {8'd0, 8'd0, 8'd0, val};
			pkt_d.last_byte = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_index_q    <= '0;
			record_length_q <= '0;
			running_sum_q   <= '0;
			pkt_valid_s1    <= 1'b0;
		end else begin
			if (accept) begin
				slot_index_q    <= (idx == LAST_SLOT) ? 7'd0 : idx + 7'd1;
				record_length_q <= len;
				running_sum_q   <= new_sum;
				pkt_valid_s1    <= 1'b1;
			end else if (pkt_take) begin
				pkt_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			pkt_s1 <= pkt_d;
	end

	assign pkt_out.valid = pkt_valid_s1;
	assign pkt_out.pkt   = pkt_s1;

endmodule

/* sv/crbe_serializer.sv */
`timescale 1ns / 1ps
// Serializer: turns a packet of bytes into start, eight data bits LSB first, stop.
// Depends on crbe_pkg; registered output, one symbol per cycle unless stalled.
module crbe_serializer import crbe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  pkt_chan_t pkt_in,
	output logic      pkt_take,
	output logic      out_valid,
	input  logic      out_ready,
	output logic      out_symbol,
	output logic      out_last
);

	byte_pkt_t  cur_q;
	logic       active_q;
	logic [1:0] byte_idx_q;
	logic [3:0] bit_idx_q;
	logic       out_valid_q;
	logic       out_symbol_q;
	logic       out_last_q;

	logic       advance;
	logic       byte_done;
	logic       pkt_done;
	logic       sym;
	logic [7:0] cur_byte;

	assign cur_byte  = cur_q.bytes[byte_idx_q];
	assign advance   = active_q && (!out_valid_q || out_ready);
	assign byte_done = (bit_idx_q == POS_STOP);
	assign pkt_done  = byte_done && (byte_idx_q == cur_q.last_byte);
	assign pkt_take  = pkt_in.valid && (!active_q || (advance && pkt_done));

	always_comb begin
		if (bit_idx_q == POS_START)
			sym = SYM_SPACE;
		else if (byte_done)
			sym = SYM_MARK;
		else
			sym = cur_byte[3'(bit_idx_q - 4'd1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			byte_idx_q  <= '0;
			bit_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (pkt_take) begin
				active_q   <= 1'b1;
				byte_idx_q <= '0;
				bit_idx_q  <= POS_START;
			end else if (advance) begin
				if (pkt_done) begin
					active_q <= 1'b0;
				end else if (byte_done) begin
					byte_idx_q <= byte_idx_q + 2'd1;
					bit_idx_q  <= POS_START;
				end else begin
					bit_idx_q <= bit_idx_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_take)
			cur_q <= pkt_in.pkt;
		if (advance) begin
			out_symbol_q <= sym;
			out_last_q   <= pkt_done;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_symbol = out_symbol_q;
	assign out_last   = out_last_q;

endmodule
